>>> design/gpc_pkg.sv
// ----------------------------------------------------------------------------
// gpc_pkg
// shared types, register map codes and mask helpers for the gpio port
// controller
// ----------------------------------------------------------------------------
package gpc_pkg;

    // bus commands
    typedef enum logic [1:0] {
        CMD_READ   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_SAMPLE = 2'd2
    } command_t;

    // register map
    localparam logic [3:0] REG_ALTFN_LO  = 4'd0;
    localparam logic [3:0] REG_ALTFN_HI  = 4'd1;
    localparam logic [3:0] REG_OUT_EN    = 4'd2;
    localparam logic [3:0] REG_PULLUP    = 4'd3;
    localparam logic [3:0] REG_OUT       = 4'd4;
    localparam logic [3:0] REG_PAD       = 4'd5;
    localparam logic [3:0] REG_DETMODE_LO = 4'd6;
    localparam logic [3:0] REG_DETMODE_HI = 4'd7;
    localparam logic [3:0] REG_INT_EN    = 4'd8;
    localparam logic [3:0] REG_PENDING   = 4'd9;

    // result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_PORT = 2'd1;
    localparam logic [1:0] STAT_BAD_REG  = 2'd2;

    // detect modes
    localparam logic [1:0] DET_LOW     = 2'd0;
    localparam logic [1:0] DET_HIGH    = 2'd1;
    localparam logic [1:0] DET_FALLING = 2'd2;
    localparam logic [1:0] DET_RISING  = 2'd3;

    localparam int WORD_W   = 32;
    localparam int IRQ_W    = 3;
    localparam int HALF_PINS = 16;

    // controller states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic latch;   // capture the incoming word
        logic exec;    // run the captured word and load the result register
    } ctrl_cmd_t;

    // one bit per existing pin
    function automatic logic [WORD_W-1:0] pin_mask(input int pins);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            m[i] = (i < pins);
        end
        return m;
    endfunction

    // two bits per existing pin in one half word
    function automatic logic [WORD_W-1:0] field_mask(input int half, input int pins);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int i = 0; i < HALF_PINS; i++)
        begin
            m[2*i]   = (half * HALF_PINS + i < pins);
            m[2*i+1] = (half * HALF_PINS + i < pins);
        end
        return m;
    endfunction

endpackage

>>> design/gpc_ctrl.sv
// ----------------------------------------------------------------------------
// gpc_ctrl
// sequencer: captures one word, executes it, and owns the result valid flag
// ----------------------------------------------------------------------------
module gpc_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    output gpc_pkg::ctrl_cmd_t cmd
);

    gpc_pkg::state_t state_reg;
    gpc_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    // result slot is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gpc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = gpc_pkg::ST_EXEC;
                end
            end
            gpc_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = gpc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gpc_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.latch = 1'b0;
        cmd.exec  = 1'b0;
        in_stall  = 1'b1;
        case (state_reg)
            gpc_pkg::ST_IDLE:
            begin
                in_stall  = 1'b0;
                cmd.latch = in_valid;
            end
            gpc_pkg::ST_EXEC:
            begin
                cmd.exec = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gpc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> design/gpc_datapath.sv
// ----------------------------------------------------------------------------
// gpc_datapath
// per-port register file, pad edge/level detect and result register
// ----------------------------------------------------------------------------
module gpc_datapath
#(
    parameter int NUM_PORTS     = 3,
    parameter int PINS_PER_PORT = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  gpc_pkg::ctrl_cmd_t cmd,
    input  logic [1:0]         command,
    input  logic [1:0]         port_index,
    input  logic [3:0]         reg_select,
    input  logic [31:0]        write_data,
    input  logic [31:0]        pad_levels,
    output logic [31:0]        read_data,
    output logic [1:0]         status,
    output logic [2:0]         port_irq
);

    localparam int          PIDX_W   = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam logic [31:0] PIN_MASK = gpc_pkg::pin_mask(PINS_PER_PORT);
    localparam logic [31:0] FLD_LO   = gpc_pkg::field_mask(0, PINS_PER_PORT);
    localparam logic [31:0] FLD_HI   = gpc_pkg::field_mask(1, PINS_PER_PORT);

    // captured word
    logic [1:0]  cmd_reg;
    logic [1:0]  port_reg;
    logic [3:0]  sel_reg;
    logic [31:0] wdata_reg;
    logic [31:0] pads_reg;

    // per-port state
    logic [31:0] altfn_lo_reg [NUM_PORTS];
    logic [31:0] altfn_hi_reg [NUM_PORTS];
    logic [31:0] out_en_reg   [NUM_PORTS];
    logic [31:0] pullup_reg   [NUM_PORTS];
    logic [31:0] out_reg      [NUM_PORTS];
    logic [31:0] detlo_reg    [NUM_PORTS];
    logic [31:0] dethi_reg    [NUM_PORTS];
    logic [31:0] int_en_reg   [NUM_PORTS];
    logic [31:0] pend_reg     [NUM_PORTS];
    logic [31:0] last_reg     [NUM_PORTS];

    // result register
    logic [31:0] rdata_reg;
    logic [1:0]  stat_reg;
    logic [2:0]  irq_reg;

    logic [PIDX_W-1:0] pidx;
    logic              port_ok;
    logic [31:0]       now_lvl;
    logic [31:0]       hit;
    logic [31:0]       cur_detlo;
    logic [31:0]       cur_dethi;
    logic [31:0]       cur_last;
    logic [31:0]       cur_pend;
    logic [1:0]        mode;

    logic        we_altfn_lo;
    logic        we_altfn_hi;
    logic        we_out_en;
    logic        we_pullup;
    logic        we_out;
    logic        we_detlo;
    logic        we_dethi;
    logic        we_int_en;
    logic        we_pend;
    logic        we_last;
    logic [31:0] pend_new;
    logic [31:0] rdata_next;
    logic [1:0]  stat_next;
    logic [3:0]  irq_all;

    assign pidx    = port_reg[PIDX_W-1:0];
    assign port_ok = ({1'b0, port_reg} < 3'(NUM_PORTS));

    assign cur_detlo = detlo_reg[pidx];
    assign cur_dethi = dethi_reg[pidx];
    assign cur_last  = last_reg[pidx];
    assign cur_pend  = pend_reg[pidx];
    assign now_lvl   = pads_reg & PIN_MASK;

    // per-pin detect
    always_comb
    begin
        hit  = '0;
        mode = gpc_pkg::DET_LOW;
        for (int pin = 0; pin < gpc_pkg::WORD_W; pin++)
        begin
            if (pin < gpc_pkg::HALF_PINS)
            begin
                mode = cur_detlo[2*pin +: 2];
            end
            else
            begin
                mode = cur_dethi[2*(pin - gpc_pkg::HALF_PINS) +: 2];
            end
            case (mode)
                gpc_pkg::DET_LOW:     hit[pin] = !now_lvl[pin];
                gpc_pkg::DET_HIGH:    hit[pin] = now_lvl[pin];
                gpc_pkg::DET_FALLING: hit[pin] = cur_last[pin] && !now_lvl[pin];
                default:              hit[pin] = !cur_last[pin] && now_lvl[pin];
            endcase
        end
    end

    // command decode
    always_comb
    begin
        we_altfn_lo = 1'b0;
        we_altfn_hi = 1'b0;
        we_out_en   = 1'b0;
        we_pullup   = 1'b0;
        we_out      = 1'b0;
        we_detlo    = 1'b0;
        we_dethi    = 1'b0;
        we_int_en   = 1'b0;
        we_pend     = 1'b0;
        we_last     = 1'b0;
        pend_new    = cur_pend;
        rdata_next  = '0;
        stat_next   = gpc_pkg::STAT_OK;
        if (!port_ok)
        begin
            stat_next = gpc_pkg::STAT_BAD_PORT;
        end
        else
        begin
            case (cmd_reg)
                gpc_pkg::CMD_SAMPLE:
                begin
                    we_pend  = 1'b1;
                    we_last  = 1'b1;
                    pend_new = cur_pend | (hit & PIN_MASK);
                end
                gpc_pkg::CMD_READ:
                begin
                    case (sel_reg)
                        gpc_pkg::REG_ALTFN_LO:   rdata_next = altfn_lo_reg[pidx];
                        gpc_pkg::REG_ALTFN_HI:   rdata_next = altfn_hi_reg[pidx];
                        gpc_pkg::REG_OUT_EN:     rdata_next = out_en_reg[pidx];
                        gpc_pkg::REG_PULLUP:     rdata_next = pullup_reg[pidx];
                        gpc_pkg::REG_OUT:        rdata_next = out_reg[pidx];
                        gpc_pkg::REG_PAD:        rdata_next = cur_last;
                        gpc_pkg::REG_DETMODE_LO: rdata_next = cur_detlo;
                        gpc_pkg::REG_DETMODE_HI: rdata_next = cur_dethi;
                        gpc_pkg::REG_INT_EN:     rdata_next = int_en_reg[pidx];
                        gpc_pkg::REG_PENDING:    rdata_next = cur_pend;
                        default:                 stat_next  = gpc_pkg::STAT_BAD_REG;
                    endcase
                end
                gpc_pkg::CMD_WRITE:
                begin
                    case (sel_reg)
                        gpc_pkg::REG_ALTFN_LO:   we_altfn_lo = 1'b1;
                        gpc_pkg::REG_ALTFN_HI:   we_altfn_hi = 1'b1;
                        gpc_pkg::REG_OUT_EN:     we_out_en   = 1'b1;
                        gpc_pkg::REG_PULLUP:     we_pullup   = 1'b1;
                        gpc_pkg::REG_OUT:        we_out      = 1'b1;
                        gpc_pkg::REG_DETMODE_LO: we_detlo    = 1'b1;
                        gpc_pkg::REG_DETMODE_HI: we_dethi    = 1'b1;
                        gpc_pkg::REG_INT_EN:     we_int_en   = 1'b1;
                        gpc_pkg::REG_PENDING:
                        begin
                            we_pend  = 1'b1;
                            pend_new = cur_pend & ~wdata_reg;
                        end
                        default:                 stat_next   = gpc_pkg::STAT_BAD_REG;
                    endcase
                end
                default:
                begin
                    stat_next = gpc_pkg::STAT_BAD_REG;
                end
            endcase
        end
    end

    // interrupt vector after this word's update
    always_comb
    begin
        irq_all = '0;
        for (int p = 0; p < NUM_PORTS; p++)
        begin
            if (port_ok && (pidx == PIDX_W'(p)))
            begin
                irq_all[p] = |(pend_new & (we_int_en ? (wdata_reg & PIN_MASK)
                                                     : int_en_reg[p]));
            end
            else
            begin
                irq_all[p] = |(pend_reg[p] & int_en_reg[p]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cmd_reg   <= command;
            port_reg  <= port_index;
            sel_reg   <= reg_select;
            wdata_reg <= write_data;
            pads_reg  <= pad_levels;
        end
        if (cmd.exec)
        begin
            rdata_reg <= rdata_next;
            stat_reg  <= stat_next;
            irq_reg   <= irq_all[2:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PORTS; p++)
            begin
                altfn_lo_reg[p] <= '0;
                altfn_hi_reg[p] <= '0;
                out_en_reg[p]   <= '0;
                pullup_reg[p]   <= '0;
                out_reg[p]      <= '0;
                detlo_reg[p]    <= '0;
                dethi_reg[p]    <= '0;
                int_en_reg[p]   <= '0;
                pend_reg[p]     <= '0;
                last_reg[p]     <= '0;
            end
        end
        else if (cmd.exec && port_ok)
        begin
            for (int p = 0; p < NUM_PORTS; p++)
            begin
                if (pidx == PIDX_W'(p))
                begin
                    if (we_altfn_lo) altfn_lo_reg[p] <= wdata_reg & FLD_LO;
                    if (we_altfn_hi) altfn_hi_reg[p] <= wdata_reg & FLD_HI;
                    if (we_out_en)   out_en_reg[p]   <= wdata_reg & PIN_MASK;
                    if (we_pullup)   pullup_reg[p]   <= wdata_reg & PIN_MASK;
                    if (we_out)      out_reg[p]      <= wdata_reg & PIN_MASK;
                    if (we_detlo)    detlo_reg[p]    <= wdata_reg & FLD_LO;
                    if (we_dethi)    dethi_reg[p]    <= wdata_reg & FLD_HI;
                    if (we_int_en)   int_en_reg[p]   <= wdata_reg & PIN_MASK;
                    if (we_pend)     pend_reg[p]     <= pend_new;
                    if (we_last)     last_reg[p]     <= now_lvl;
                end
            end
        end
    end

    assign read_data = rdata_reg;
    assign status    = stat_reg;
    assign port_irq  = irq_reg;

endmodule

>>> design/gpio_port_controller_core.sv
// ----------------------------------------------------------------------------
// gpio_port_controller_core
// multi-port gpio controller with edge and level interrupt detect
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall) carries one word: a register read,
//   a register write, or a pad sample for one port
//   output channel (out_valid / out_stall) returns one word per input word:
//   read_data, status and the port_irq vector after that word's update
// sequencing
//   a word is captured at its accepting edge and executed from the exec state
//   once the result register is free, which then offers its result; the
//   sequencer takes no new word until the last one has executed
// stall behavior
//   a held result does not block capture of the next word; execution of that
//   word waits until the result register is free, and the input stalls then
// reset
//   rst_n clears every port register, the pending and pad words and the
//   sequencer; no result is valid after reset
// ----------------------------------------------------------------------------
module gpio_port_controller_core
#(
    parameter int NUM_PORTS     = 3,
    parameter int PINS_PER_PORT = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input words
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [1:0]  port_index,
    input  logic [3:0]  reg_select,
    input  logic [31:0] write_data,
    input  logic [31:0] pad_levels,
    // result words
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] read_data,
    output logic [1:0]  status,
    output logic [2:0]  port_irq
);

    // sequencer commands into the datapath
    gpc_pkg::ctrl_cmd_t cmd;

    // capture / execute sequencer and result valid flag
    gpc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // port registers, detect logic and result register
    gpc_datapath
    #(
        .NUM_PORTS     (NUM_PORTS),
        .PINS_PER_PORT (PINS_PER_PORT)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .command    (command),
        .port_index (port_index),
        .reg_select (reg_select),
        .write_data (write_data),
        .pad_levels (pad_levels),
        .read_data  (read_data),
        .status     (status),
        .port_irq   (port_irq)
    );

endmodule

>>> design/gpc_checker.sv
// ----------------------------------------------------------------------------
// gpc_checker
// port-level checks for the gpio port controller
// ----------------------------------------------------------------------------
module gpc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] read_data,
    input logic [1:0]  status
);

    // held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // held result does not change
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(read_data) && $stable(status))
        else $error("result changed while stalled");

    // input words are never accepted back to back
    a_in_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken on back to back cycles");

    // no undefined status code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= gpc_pkg::STAT_BAD_REG)
        else $error("undefined status code");

    // failed words return zero data
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != gpc_pkg::STAT_OK |-> read_data == 32'd0)
        else $error("nonzero data on error");

endmodule

bind gpio_port_controller_core gpc_checker u_gpc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .read_data (read_data),
    .status    (status)
);
